@@ rtl/max_min_gap_placement_search_defines.svh @@
// ----------------------------------------------------------------------------
// max_min_gap_placement_search_defines
// assertion macros used by mmgps_ctrl
// ----------------------------------------------------------------------------
`ifndef MAX_MIN_GAP_PLACEMENT_SEARCH_DEFINES_SVH
`define MAX_MIN_GAP_PLACEMENT_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
// a holds now, so b holds in the same cycle
`define MMGPS_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("mmgps check failed");
// a holds now, so b holds in the next cycle
`define MMGPS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("mmgps check failed");
`else
`define MMGPS_ASSERT_NOW(label, clk, rst_n, a, b)
`define MMGPS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/mmgps_pkg.sv @@
// ----------------------------------------------------------------------------
// mmgps_pkg
// types and constants of the max-min gap placement search
// ----------------------------------------------------------------------------
package mmgps_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int POS_W         = 31;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int NEED_W        = 11;
    localparam logic [NEED_W-1:0] NEED_RESET = NEED_W'(2);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last_position;
    } t_in_beat;

    typedef struct packed {
        logic [POS_W-1:0] best_gap;
        logic             found;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE, S_SINIT, S_SI_CHK, S_SV, S_SJ, S_SC, S_MIN, S_RL,
        S_SPAN, S_BS, S_CR, S_CE, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_SORT_INIT, CMD_RD_I, CMD_TAKE_V, CMD_RD_JM1,
        CMD_SHIFT, CMD_PLACE, CMD_RD_0, CMD_TAKE_MIN, CMD_RD_LAST, CMD_TAKE_SPAN,
        CMD_SPAN_RESULT, CMD_CHK_INIT, CMD_CHK_STEP, CMD_FIT, CMD_MISS, CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic i_lt_n;
        logic j_zero;
        logic gt;
        logic cand_ok;
        logic hit;
        logic lo_le_hi;
        logic mid_zero;
        logic need_le1;
        logic out_busy;
    } t_status;

endpackage

@@ rtl/mmgps_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmgps_ctrl
// sequencer for load, insertion sort and binary search
// ----------------------------------------------------------------------------
`include "max_min_gap_placement_search_defines.svh"

module mmgps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    input  mmgps_pkg::t_status i_status,
    output mmgps_pkg::t_cmd    o_cmd,
    output logic               o_in_stall
);

    mmgps_pkg::t_state r_state;
    mmgps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmgps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = mmgps_pkg::CMD_NONE;
        case (r_state)
            mmgps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = mmgps_pkg::CMD_LOAD;
                    if (i_in_last) n_state = mmgps_pkg::S_SINIT;
                end
            end
            mmgps_pkg::S_SINIT: begin
                o_cmd   = mmgps_pkg::CMD_SORT_INIT;
                n_state = mmgps_pkg::S_SI_CHK;
            end
            mmgps_pkg::S_SI_CHK: begin
                if (i_status.i_lt_n) begin
                    o_cmd   = mmgps_pkg::CMD_RD_I;
                    n_state = mmgps_pkg::S_SV;
                end else begin
                    o_cmd   = mmgps_pkg::CMD_RD_0;
                    n_state = mmgps_pkg::S_MIN;
                end
            end
            mmgps_pkg::S_SV: begin
                o_cmd   = mmgps_pkg::CMD_TAKE_V;
                n_state = mmgps_pkg::S_SJ;
            end
            mmgps_pkg::S_SJ: begin
                if (i_status.j_zero) begin
                    o_cmd   = mmgps_pkg::CMD_PLACE;
                    n_state = mmgps_pkg::S_SI_CHK;
                end else begin
                    o_cmd   = mmgps_pkg::CMD_RD_JM1;
                    n_state = mmgps_pkg::S_SC;
                end
            end
            mmgps_pkg::S_SC: begin
                if (i_status.gt) begin
                    o_cmd   = mmgps_pkg::CMD_SHIFT;
                    n_state = mmgps_pkg::S_SJ;
                end else begin
                    o_cmd   = mmgps_pkg::CMD_PLACE;
                    n_state = mmgps_pkg::S_SI_CHK;
                end
            end
            mmgps_pkg::S_MIN: begin
                o_cmd   = mmgps_pkg::CMD_TAKE_MIN;
                n_state = mmgps_pkg::S_RL;
            end
            mmgps_pkg::S_RL: begin
                o_cmd   = mmgps_pkg::CMD_RD_LAST;
                n_state = mmgps_pkg::S_SPAN;
            end
            mmgps_pkg::S_SPAN: begin
                o_cmd   = mmgps_pkg::CMD_TAKE_SPAN;
                n_state = mmgps_pkg::S_BS;
            end
            mmgps_pkg::S_BS: begin
                if (i_status.need_le1) begin
                    o_cmd   = mmgps_pkg::CMD_SPAN_RESULT;
                    n_state = mmgps_pkg::S_OUT;
                end else if (i_status.lo_le_hi) begin
                    o_cmd   = mmgps_pkg::CMD_CHK_INIT;
                    n_state = mmgps_pkg::S_CR;
                end else begin
                    n_state = mmgps_pkg::S_OUT;
                end
            end
            mmgps_pkg::S_CR: begin
                if (i_status.i_lt_n) begin
                    o_cmd   = mmgps_pkg::CMD_RD_I;
                    n_state = mmgps_pkg::S_CE;
                end else if (i_status.mid_zero) begin
                    n_state = mmgps_pkg::S_OUT;
                end else begin
                    o_cmd   = mmgps_pkg::CMD_MISS;
                    n_state = mmgps_pkg::S_BS;
                end
            end
            mmgps_pkg::S_CE: begin
                if (i_status.cand_ok && i_status.hit) begin
                    o_cmd   = mmgps_pkg::CMD_FIT;
                    n_state = mmgps_pkg::S_BS;
                end else begin
                    o_cmd   = mmgps_pkg::CMD_CHK_STEP;
                    n_state = mmgps_pkg::S_CR;
                end
            end
            mmgps_pkg::S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd   = mmgps_pkg::CMD_EMIT;
                    n_state = mmgps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mmgps_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != mmgps_pkg::S_IDLE);

    `MMGPS_ASSERT_NOW(a_emit_free, i_clk, i_rst_n,
        o_cmd == mmgps_pkg::CMD_EMIT, !i_status.out_busy)
    `MMGPS_ASSERT_NEXT(a_last_starts, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in_last, r_state == mmgps_pkg::S_SINIT)
    `MMGPS_ASSERT_NOW(a_cmp_after_read, i_clk, i_rst_n,
        r_state == mmgps_pkg::S_SC, $past(o_cmd) == mmgps_pkg::CMD_RD_JM1)

endmodule

@@ rtl/mmgps_dp.sv @@
// ----------------------------------------------------------------------------
// mmgps_dp
// position store, sort and search registers, result register
// ----------------------------------------------------------------------------
module mmgps_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mmgps_pkg::t_cmd         i_cmd,
    input  mmgps_pkg::t_in_beat     i_in_data,
    input  logic                    i_cfg_we,
    input  logic [mmgps_pkg::NEED_W-1:0] i_cfg_data,
    input  logic                    i_out_stall,
    output mmgps_pkg::t_status      o_status,
    output logic                    o_out_valid,
    output mmgps_pkg::t_out_beat    o_out_data
);

    localparam int PW = mmgps_pkg::POS_W;
    localparam int CW = mmgps_pkg::CNT_W;
    localparam int AW = mmgps_pkg::ADDR_W;

    logic [PW-1:0] r_mem [mmgps_pkg::MAX_POSITIONS];
    logic [PW-1:0] r_rdata;
    logic [CW-1:0] r_count, r_n, r_i, r_j;
    logic [PW-1:0] r_v, r_min, r_prev, r_hi, r_mid, r_best;
    logic [PW:0]   r_lo;
    logic [mmgps_pkg::NEED_W-1:0] r_need, r_placed;
    logic          r_ok, r_out_valid;
    mmgps_pkg::t_out_beat r_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] wdata;
    logic          re;
    logic [PW:0]   diff;
    logic [PW-1:0] mid_calc;

    // write and read port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_j[AW-1:0];
        wdata = r_v;
        re    = 1'b1;
        raddr = r_i[AW-1:0];
        case (i_cmd)
            mmgps_pkg::CMD_LOAD: begin
                we    = (r_count < CW'(mmgps_pkg::MAX_POSITIONS));
                waddr = r_count[AW-1:0];
                wdata = i_in_data.position;
            end
            mmgps_pkg::CMD_SHIFT: begin
                we    = 1'b1;
                wdata = r_rdata;
            end
            mmgps_pkg::CMD_PLACE:   we = 1'b1;
            mmgps_pkg::CMD_RD_I:    re = 1'b1;
            mmgps_pkg::CMD_RD_JM1:  raddr = AW'(r_j - CW'(1));
            mmgps_pkg::CMD_RD_0:    raddr = '0;
            mmgps_pkg::CMD_RD_LAST: raddr = AW'(r_n - CW'(1));
            default:                re = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rdata <= r_mem[raddr];
    end

    assign diff     = {1'b0, r_hi} - r_lo;
    assign mid_calc = r_lo[PW-1:0] + diff[PW:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_need      <= mmgps_pkg::NEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_need <= i_cfg_data;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (i_cmd)
                mmgps_pkg::CMD_LOAD: begin
                    if (r_count < CW'(mmgps_pkg::MAX_POSITIONS)) r_count <= r_count + CW'(1);
                end
                mmgps_pkg::CMD_SORT_INIT: r_count <= '0;
                mmgps_pkg::CMD_EMIT:      r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            mmgps_pkg::CMD_SORT_INIT: begin
                r_n <= r_count;
                r_i <= CW'(1);
            end
            mmgps_pkg::CMD_TAKE_V: begin
                r_v <= r_rdata;
                r_j <= r_i;
            end
            mmgps_pkg::CMD_SHIFT: r_j <= r_j - CW'(1);
            mmgps_pkg::CMD_PLACE: r_i <= r_i + CW'(1);
            mmgps_pkg::CMD_TAKE_MIN: r_min <= r_rdata;
            mmgps_pkg::CMD_TAKE_SPAN: begin
                r_lo   <= '0;
                r_hi   <= r_rdata - r_min;
                r_best <= '0;
                r_ok   <= 1'b0;
            end
            mmgps_pkg::CMD_SPAN_RESULT: begin
                r_best <= r_hi;
                r_ok   <= 1'b1;
            end
            mmgps_pkg::CMD_CHK_INIT: begin
                r_mid    <= mid_calc;
                r_prev   <= r_min;
                r_placed <= mmgps_pkg::NEED_W'(1);
                r_i      <= CW'(1);
            end
            mmgps_pkg::CMD_CHK_STEP: begin
                r_i <= r_i + CW'(1);
                if (o_status.cand_ok) begin
                    r_placed <= r_placed + mmgps_pkg::NEED_W'(1);
                    r_prev   <= r_rdata;
                end
            end
            mmgps_pkg::CMD_FIT: begin
                r_best <= r_mid;
                r_ok   <= 1'b1;
                r_lo   <= {1'b0, r_mid} + (PW+1)'(1);
            end
            mmgps_pkg::CMD_MISS: r_hi <= r_mid - PW'(1);
            mmgps_pkg::CMD_EMIT: begin
                r_out.best_gap <= r_ok ? r_best : '0;
                r_out.found    <= r_ok;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.i_lt_n   = (r_i < r_n);
        o_status.j_zero   = (r_j == '0);
        o_status.gt       = (r_rdata > r_v);
        o_status.cand_ok  = ((r_rdata - r_prev) >= r_mid);
        o_status.hit      = ((r_placed + mmgps_pkg::NEED_W'(1)) >= r_need);
        o_status.lo_le_hi = (r_lo <= {1'b0, r_hi});
        o_status.mid_zero = (r_mid == '0);
        o_status.need_le1 = (r_need <= mmgps_pkg::NEED_W'(1));
        o_status.out_busy = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/max_min_gap_placement_search.sv @@
// ----------------------------------------------------------------------------
// max_min_gap_placement_search
// largest minimum gap for placing a configured number of points on a set
// ----------------------------------------------------------------------------
// Positions load one beat per cycle into a 1024-entry store; beats beyond
// 1024 are dropped. The beat marked last_position closes the set: the store
// is insertion sorted in place through its single write and registered read
// port, then the gap is binary searched from 0 to the span, each probe
// walking the sorted store entry by entry, at most 32 probes. One result
// beat follows: best_gap and found, found low when no placement fits. With
// one point or none requested the answer is the span. The input stalls from
// the last beat until the result is written to the output register;
// points_to_place is written any time the block is idle, and its write port
// is always ready.
// ----------------------------------------------------------------------------
module max_min_gap_placement_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mmgps_pkg::t_in_beat            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mmgps_pkg::t_out_beat           o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mmgps_pkg::NEED_W-1:0]   i_cfg_data
);

    mmgps_pkg::t_cmd    cmd;
    mmgps_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    // sequencer: owns the input handshake
    mmgps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_position),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // store, search registers and output register
    mmgps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/max_min_gap_placement_search_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_min_gap_placement_search_tb
// self-checking bench for the max-min gap placement search
// ----------------------------------------------------------------------------
// A short directed table opens the run. It covers the field extremes, a single
// point, one and zero points requested, more points than positions, and
// duplicate positions. A full store with overflow beats follows, and then
// random position sets under several points_to_place settings. Every result
// beat is checked against a gap search computed in the bench, or against a
// value typed into the table. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module max_min_gap_placement_search_tb;

    localparam int HALF_PERIOD  = 2;
    localparam int STALL_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 550;

    typedef struct {
        logic             set_need;   // write points_to_place before this beat
        logic [mmgps_pkg::NEED_W-1:0] need;
        logic [mmgps_pkg::POS_W-1:0]  position;
        logic             last_position;
        logic             known;      // expected result typed in below
        logic [mmgps_pkg::POS_W-1:0]  gap;
        logic             found;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    mmgps_pkg::t_in_beat  i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    mmgps_pkg::t_out_beat o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [mmgps_pkg::NEED_W-1:0] i_cfg_data = '0;

    // bench copy of the block state
    logic [mmgps_pkg::NEED_W-1:0] need_now = mmgps_pkg::NEED_RESET;
    logic [mmgps_pkg::POS_W-1:0]  set_positions[$];
    mmgps_pkg::t_out_beat         gap_queue[$];
    int               errors = 0;
    int               idle_cnt = 0;
    bit               quiet = 1'b0;     // no idling in the last stretch
    int               out_hold = 0;

    max_min_gap_placement_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // greedy left-to-right placement with no two points closer than gap
    function automatic bit greedy_fits(ref logic [mmgps_pkg::POS_W-1:0] s[$],
                                       input longint gap, input int need);
        int     placed;
        longint prev;
        placed = 1;
        if (need <= 1) return 1'b1;
        prev = s[0];
        for (int i = 1; i < s.size(); i++) begin
            if (longint'(s[i]) - prev >= gap) begin
                placed++;
                prev = s[i];
                if (placed >= need) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // binary search of the largest workable minimum gap over one set
    function automatic mmgps_pkg::t_out_beat search_best_gap(
            input logic [mmgps_pkg::POS_W-1:0] pos[$],
            input logic [mmgps_pkg::NEED_W-1:0] need);
        logic [mmgps_pkg::POS_W-1:0] s[$];
        longint lo, hi, mid, best;
        bit     ok;
        mmgps_pkg::t_out_beat r;
        s = pos;
        s.sort();
        lo = 0;
        hi = longint'(s[s.size()-1]) - longint'(s[0]);
        best = 0;
        ok = 1'b0;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (greedy_fits(s, mid, int'(need))) begin
                best = mid;
                ok = 1'b1;
                lo = mid + 1;
            end else begin
                if (mid == 0) break;
                hi = mid - 1;
            end
        end
        r.best_gap = ok ? best[mmgps_pkg::POS_W-1:0] : '0;
        r.found    = ok;
        return r;
    endfunction

    // one beat on the input channel; the caller's next beat may follow at once
    task automatic send_position(input logic [mmgps_pkg::POS_W-1:0] pos,
                                 input logic last, input bit typed,
                                 input mmgps_pkg::t_out_beat typed_res);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data.position      <= pos;
        i_in_data.last_position <= last;
        do @(posedge i_clk); while (o_in_stall);
        // store full: further positions are dropped
        if (set_positions.size() < mmgps_pkg::MAX_POSITIONS) set_positions.push_back(pos);
        if (last) begin
            gap_queue.push_back(typed ? typed_res : search_best_gap(set_positions, need_now));
            set_positions.delete();
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        wait (gap_queue.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    // points_to_place is written only with the block idle
    task automatic write_need(input logic [mmgps_pkg::NEED_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        need_now = v;
    endtask

    // result side: check each accepted beat, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gap_queue.size() == 0) begin
                $display("%0t: unexpected result beat gap %0d found %0b", $time,
                         o_out_data.best_gap, o_out_data.found);
                errors++;
            end else begin
                if (o_out_data.best_gap !== gap_queue[0].best_gap) begin
                    $display("%0t: best_gap expected %0d actual %0d", $time,
                             gap_queue[0].best_gap, o_out_data.best_gap);
                    errors++;
                end
                if (o_out_data.found !== gap_queue[0].found) begin
                    $display("%0t: found expected %0b actual %0b", $time,
                             gap_queue[0].found, o_out_data.found);
                    errors++;
                end
                void'(gap_queue.pop_front());
            end
        end
        if (out_hold > 0) begin
            out_hold--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            out_hold = $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no beat accepted anywhere
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= STALL_LIMIT) begin
            $display("max_min_gap_placement_search verification failed");
            $finish;
        end
    end

    initial begin
        t_row      rows[$];
        mmgps_pkg::t_out_beat res;
        int        items, len, mode;
        logic [mmgps_pkg::POS_W-1:0]  p;
        logic [mmgps_pkg::NEED_W-1:0] needs[8];

        needs = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd0, 11'd1024, 11'd2047, 11'd6};
        // set_need, need, position, last, known, gap, found
        rows = '{
            // after reset two points: a lone zero fits nothing
            '{0, 0, 31'd0,          1, 1, 0, 0},
            // extremes give the full span
            '{0, 0, 31'h7FFFFFFF,   0, 0, 0, 0},
            '{0, 0, 31'd0,          1, 1, 31'h7FFFFFFF, 1},
            // single position, two points: nothing fits
            '{0, 0, 31'd1234,       1, 1, 0, 0},
            // one point requested: span
            '{1, 1, 31'h55555555,   0, 0, 0, 0},
            '{0, 0, 31'h2AAAAAAA,   1, 1, 31'h2AAAAAAB, 1},
            '{0, 0, 31'd77,         1, 1, 0, 1},
            // zero points requested: span
            '{1, 0, 31'd5,          0, 0, 0, 0},
            '{0, 0, 31'd9,          1, 1, 31'd4, 1},
            // duplicates, three points: gap zero still fits
            '{1, 3, 31'd7,          0, 0, 0, 0},
            '{0, 0, 31'd7,          0, 0, 0, 0},
            '{0, 0, 31'd7,          1, 1, 0, 1},
            // unsorted arrival, predicted
            '{0, 0, 31'd40,         0, 0, 0, 0},
            '{0, 0, 31'd1,          0, 0, 0, 0},
            '{0, 0, 31'd17,         0, 0, 0, 0},
            '{0, 0, 31'd2,          1, 0, 0, 0},
            // more points than positions
            '{1, 1024, 31'd3,       0, 0, 0, 0},
            '{0, 0, 31'd8,          1, 1, 0, 0},
            '{1, 2047, 31'd100,     0, 0, 0, 0},
            '{0, 0, 31'd0,          0, 0, 0, 0},
            '{0, 0, 31'h7FFFFFFF,   1, 1, 0, 0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].set_need) write_need(rows[k].need);
            res.best_gap = rows[k].gap;
            res.found    = rows[k].found;
            send_position(rows[k].position, rows[k].last_position, rows[k].known, res);
        end

        // full store: ascending so the sort stays short, then dropped beats
        write_need(11'd3);
        for (int k = 0; k < mmgps_pkg::MAX_POSITIONS + 6; k++) begin
            send_position(mmgps_pkg::POS_W'(k * 1000 + $urandom_range(0, 999)),
                          k == mmgps_pkg::MAX_POSITIONS + 5, 1'b0, res);
        end
        // hold off until the search result is out
        wait_drained();

        items = 0;
        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 29) == 0) write_need(needs[$urandom_range(0, 7)]);
            if (items > RANDOM_ITEMS - 200) quiet = 1'b1;
            len  = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 12);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: p = mmgps_pkg::POS_W'($urandom);
                    1: p = mmgps_pkg::POS_W'($urandom_range(0, 50));
                    2: p = ($urandom_range(0, 1) != 0) ? 31'h7FFFFFFF
                                                       : mmgps_pkg::POS_W'($urandom_range(0, 3));
                    default: p = mmgps_pkg::POS_W'($urandom_range(0, 100000));
                endcase
                send_position(p, k == len - 1, 1'b0, res);
            end
            items += len;
        end
        i_in_valid <= 1'b0;

        wait (gap_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("max_min_gap_placement_search verification clean");
        end else begin
            $display("max_min_gap_placement_search verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/mmgps_pkg.sv
rtl/mmgps_ctrl.sv
rtl/mmgps_dp.sv
rtl/max_min_gap_placement_search.sv
tb/max_min_gap_placement_search_tb.sv
